// ===== rtl/ccfr_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the frame receiver.
package ccfr_pkg;

	localparam int           MAX_FRAME   = 256;
	localparam logic [8:0]   FRAME_LIMIT = 9'(MAX_FRAME);
	localparam logic [8:0]   LEN_SAT     = 9'd511;
	localparam logic [9:0]   IDLE_MAX    = 10'd1023;
	localparam logic [9:0]   TIMEOUT_RST = 10'd10;
	localparam logic [15:0]  CRC_INIT    = 16'hFFFF;
	localparam logic [15:0]  CRC_POLY    = 16'hA001;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TIMEOUT  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [8:0]  frame_length;
		logic [15:0] frame_crc;
	} result_t;

	// reflected CRC-16 update, one byte, bit-serial steps unrolled
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

// ===== rtl/crc_checked_frame_receiver.sv =====
// Top level: input register, frame core, result register and timeout register.
//
//  channel | direction | handshake          | payload
//  in      | to block  | in_valid/in_stall   | func, rx_byte
//  out     | from block| out_valid/out_stall | status, frame_length, frame_crc
//  cfg     | to block  | cfg_we              | cfg_wdata (timeout_ticks)
//
// One item per cycle while no stalled result is held; input register, then result register.
// The CRC byte update and the result decision sit between the input and result registers.
// Reset clears the frame state and sets the timeout to 10 ticks.
// A stalled result holds; the input register still takes one more item behind it.
module crc_checked_frame_receiver import ccfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [8:0]  frame_length,
	output logic [15:0] frame_crc,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata
);

	logic        vld_s1;
	logic        func_s1;
	logic [7:0]  byte_s1;
	logic [9:0]  timeout_q;
	logic        out_vld_q;
	result_t     out_q;
	logic        adv_s1;
	logic        res_valid;
	result_t     res;

	assign adv_s1   = !out_vld_q || !out_stall;
	assign in_stall = vld_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			func_s1 <= func;
			byte_s1 <= rx_byte;
		end
	end

	ccfr_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (vld_s1 && adv_s1),
		.func          (func_s1),
		.rx_byte       (byte_s1),
		.timeout_ticks (timeout_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= vld_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && vld_s1 && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_vld_q;
	assign status       = out_q.status;
	assign frame_length = out_q.frame_length;
	assign frame_crc    = out_q.frame_crc;

endmodule

// ===== rtl/ccfr_core.sv =====
// Frame state, CRC tracking, idle timer and result decision for one item.
module ccfr_core import ccfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        func,
	input  logic [7:0]  rx_byte,
	input  logic [9:0]  timeout_ticks,
	output logic        res_valid,
	output result_t     res
);

	logic [15:0] crc_q;
	logic [7:0]  recent_q;
	logic [7:0]  older_q;
	logic [8:0]  bytes_q;
	logic [9:0]  idle_q;

	logic [15:0] crc_upd;
	logic [8:0]  cnt_n;
	logic [9:0]  idle_n;
	logic        match;
	logic        ovf;
	logic        tmo;

	always_comb begin
		crc_upd = (bytes_q >= 9'd2) ? crc_byte(crc_q, older_q) : crc_q;
		cnt_n   = (bytes_q < LEN_SAT) ? bytes_q + 9'd1 : bytes_q;
		idle_n  = (idle_q < IDLE_MAX) ? idle_q + 10'd1 : idle_q;
		match   = (cnt_n >= 9'd3) && ({rx_byte, recent_q} == crc_upd);
		ovf     = (cnt_n >= FRAME_LIMIT);
		tmo     = (idle_n >= timeout_ticks);

		res_valid = 1'b0;
		res       = '{status: ST_OK, frame_length: cnt_n, frame_crc: crc_upd};
		if (!func) begin
			if (match) begin
				res_valid = 1'b1;
			end else if (ovf) begin
				res_valid = 1'b1;
				res = '{status: ST_OVERFLOW, frame_length: cnt_n, frame_crc: 16'd0};
			end
		end else if (tmo) begin
			res_valid = 1'b1;
			res = '{status: ST_TIMEOUT, frame_length: bytes_q, frame_crc: 16'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= CRC_INIT;
			recent_q <= 8'd0;
			older_q  <= 8'd0;
			bytes_q  <= 9'd0;
			idle_q   <= 10'd0;
		end else if (en) begin
			if (res_valid) begin
				crc_q    <= CRC_INIT;
				recent_q <= 8'd0;
				older_q  <= 8'd0;
				bytes_q  <= 9'd0;
				idle_q   <= 10'd0;
			end else if (!func) begin
				crc_q    <= crc_upd;
				older_q  <= recent_q;
				recent_q <= rx_byte;
				bytes_q  <= cnt_n;
				idle_q   <= 10'd0;
			end else begin
				idle_q   <= idle_n;
			end
		end
	end

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		en && res_valid |=> bytes_q == 9'd0 && crc_q == CRC_INIT && idle_q == 10'd0)
		else $error("frame state not cleared after result");

	a_frame_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_q < FRAME_LIMIT)
		else $error("frame length passed bound");

	a_ok_min_len: assert property (@(posedge clk) disable iff (!arst_n)
		en && res_valid && res.status == ST_OK |-> res.frame_length >= 9'd3)
		else $error("CRC match on short frame");

	a_byte_clears_idle: assert property (@(posedge clk) disable iff (!arst_n)
		en && !func |=> idle_q == 10'd0)
		else $error("idle count not cleared by byte");

endmodule

// ===== verif/tb_crc_checked_frame_receiver.sv =====
// Testbench for crc_checked_frame_receiver: queued byte/tick items, predicted results, stalls.
module tb_crc_checked_frame_receiver;
	import ccfr_pkg::*;

	typedef struct packed {
		logic       f;
		logic [7:0] b;
	} rx_item_t;

	typedef logic [7:0] byte_q_t[$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        func = 1'b0;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [8:0]  frame_length;
	logic [15:0] frame_crc;
	logic        cfg_we = 1'b0;
	logic [9:0]  cfg_wdata = 10'd0;

	rx_item_t pending_items[$];
	result_t  due_results[$];
	int       n_queued = 0;
	int       n_accepted = 0;
	int       n_errors = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;

	// receiver shadow state
	logic [15:0] m_crc = CRC_INIT;
	logic [7:0]  m_recent = 8'd0;
	logic [7:0]  m_older = 8'd0;
	logic [8:0]  m_count = 9'd0;
	logic [9:0]  m_idle = 10'd0;
	logic [9:0]  m_timeout = TIMEOUT_RST;

	crc_checked_frame_receiver i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.frame_length (frame_length),
		.frame_crc    (frame_crc),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic logic [15:0] crc16_add(input logic [15:0] c, input logic [7:0] d);
		logic [15:0] r;
		logic        fb;
		r = c;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ d[k];
			r = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return r;
	endfunction

	task automatic restart_frame();
		m_crc = CRC_INIT;
		m_recent = 8'd0;
		m_older = 8'd0;
		m_count = 9'd0;
		m_idle = 10'd0;
	endtask

	task automatic track_item(input logic f, input logic [7:0] b);
		result_t r;
		if (f == 1'b0) begin
			m_idle = 10'd0;
			if (m_count >= 9'd2)
				m_crc = crc16_add(m_crc, m_older);
			m_older = m_recent;
			m_recent = b;
			if (m_count < LEN_SAT)
				m_count++;
			if (m_count >= 9'd3 && {m_recent, m_older} == m_crc) begin
				r.status = ST_OK;
				r.frame_length = m_count;
				r.frame_crc = m_crc;
				due_results.push_back(r);
				restart_frame();
			end else if (m_count >= FRAME_LIMIT) begin
				r.status = ST_OVERFLOW;
				r.frame_length = m_count;
				r.frame_crc = 16'h0000;
				due_results.push_back(r);
				restart_frame();
			end
		end else begin
			if (m_idle < IDLE_MAX)
				m_idle++;
			if (m_idle >= m_timeout) begin
				r.status = ST_TIMEOUT;
				r.frame_length = m_count;
				r.frame_crc = 16'h0000;
				due_results.push_back(r);
				restart_frame();
			end
		end
	endtask

	// sender
	always @(posedge clk) begin
		logic     busy;
		rx_item_t nxt;
		if (arst_n) begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				track_item(func, rx_byte);
				n_accepted++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_items.pop_front();
					in_valid <= 1'b1;
					func <= nxt.f;
					rx_byte <= nxt.b;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$error("unexpected result: status %0d length %0d crc %h",
						status, frame_length, frame_crc);
					n_errors++;
				end else begin
					e = due_results.pop_front();
					if (status !== e.status) begin
						$error("status mismatch: expected %0d, got %0d", e.status, status);
						n_errors++;
					end
					if (frame_length !== e.frame_length) begin
						$error("frame_length mismatch: expected %0d, got %0d",
							e.frame_length, frame_length);
						n_errors++;
					end
					if (frame_crc !== e.frame_crc) begin
						$error("frame_crc mismatch: expected %h, got %h", e.frame_crc, frame_crc);
						n_errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic push_byte(input logic [7:0] b);
		rx_item_t it;
		it.f = 1'b0;
		it.b = b;
		pending_items.push_back(it);
		n_queued++;
	endtask

	task automatic push_ticks(input int n);
		rx_item_t it;
		for (int k = 0; k < n; k++) begin
			it.f = 1'b1;
			it.b = 8'($urandom_range(255));
			pending_items.push_back(it);
			n_queued++;
		end
	endtask

	// body, optional idle ticks between bytes (at most gap_max each), then CRC low/high
	task automatic push_frame(input byte_q_t body, input int gap_max);
		logic [15:0] c;
		c = CRC_INIT;
		foreach (body[k]) begin
			push_byte(body[k]);
			c = crc16_add(c, body[k]);
			if (gap_max > 0 && $urandom_range(4) == 0)
				push_ticks($urandom_range(1, gap_max));
		end
		push_byte(c[7:0]);
		push_byte(c[15:8]);
	endtask

	task automatic push_random_frame(input int len, input int gap_max);
		byte_q_t body;
		for (int k = 0; k < len; k++)
			body.push_back(8'($urandom_range(255)));
		push_frame(body, gap_max);
	endtask

	task automatic wait_until_quiet();
		while (n_accepted != n_queued || due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [9:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_timeout = v;
	endtask

	task automatic run_random(input int count);
		int start;
		int sel;
		int tmo;
		int gap;
		start = n_queued;
		tmo = int'(m_timeout);
		gap = (tmo > 1) ? ((tmo - 1 < 6) ? tmo - 1 : 6) : 0;
		while (n_queued - start < count) begin
			sel = $urandom_range(99);
			if (sel < 70) begin
				if ($urandom_range(9) == 0)
					push_random_frame($urandom_range(13, 40), gap);
				else
					push_random_frame($urandom_range(1, 12), gap);
			end else if (sel < 85) begin
				push_ticks($urandom_range(1, tmo + 2));
			end else begin
				// broken frame, abandoned by a full idle run
				for (int k = $urandom_range(1, 6); k > 0; k--)
					push_byte(8'($urandom_range(255)));
				push_ticks(tmo);
			end
		end
	endtask

	initial begin
		byte_q_t body;
		send_idle_pct = 29;
		recv_stall_pct = 57;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// default timeout of 10
		push_ticks(10);
		body = '{8'h00};
		push_frame(body, 0);
		body = '{8'hFF, 8'hFF};
		push_frame(body, 0);
		body = '{8'h01, 8'h80, 8'h7F};
		push_frame(body, 9);
		push_byte(8'hAA);
		push_byte(8'h55);
		push_ticks(10);
		push_ticks(9);
		push_byte(8'hFF);
		push_ticks(10);
		wait_until_quiet();

		// zero timeout behaves as one
		set_timeout(10'd0);
		push_byte(8'h05);
		push_ticks(1);
		push_ticks(1);
		body = '{8'h7E};
		push_frame(body, 0);
		wait_until_quiet();

		set_timeout(10'($urandom_range(2, 20)));
		run_random(45);
		wait_until_quiet();

		send_idle_pct = 57;
		recv_stall_pct = 29;
		set_timeout(10'd1);
		run_random(45);
		wait_until_quiet();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_timeout(10'($urandom_range(5, 60)));
		run_random(45);
		// size bound without a match
		for (int k = 0; k < 256; k++)
			push_byte(8'($urandom_range(255)));
		push_ticks(int'(m_timeout));
		wait_until_quiet();

		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#400000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ccfr_pkg.sv
rtl/ccfr_core.sv
rtl/crc_checked_frame_receiver.sv
verif/tb_crc_checked_frame_receiver.sv
